// File: hw/rtl/lrdg_pkg.sv
// Shared types and constants of the linear resampler with downmix and gain.
`timescale 1ns / 1ps
`default_nettype none
package lrdg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 21;
    localparam int GAIN_W   = 15;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [POS_W-1:0]  ONE_POS    = 21'd65536;
    localparam logic [POS_W-1:0]  TWO_POS    = 21'd131072;
    localparam logic [POS_W-1:0]  STEP_LIMIT = 21'd1048576;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 15'd4096;
    localparam logic [GAIN_W-1:0] GAIN_LIMIT = 15'd16384;

    localparam logic [2:0] REG_PHASE_STEP    = 3'd0;
    localparam logic [2:0] REG_START_FRAC    = 3'd1;
    localparam logic [2:0] REG_STEREO_MODE   = 3'd2;
    localparam logic [2:0] REG_VOICE_GAIN    = 3'd3;
    localparam logic [2:0] REG_ACTIVE_VOICES = 3'd4;

    typedef struct packed {
        logic accept;
        logic load_start;
        logic sel_b;
        logic mul;
        logic mix;
        logic gmul;
        logic emit;
        logic wrap;
        logic commit;
        logic div_load;
        logic div_step;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic fin;
        logic in_range;
        logic out_free;
        logic cfg_wr;
        logic div_last;
    } t_status;

endpackage
`default_nettype wire

// File: hw/rtl/linear_resampler_downmix_gain_unit.sv
// Top level of the linear resampler with stereo downmix and voice gain.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready   | i_left_sample, i_right_sample, i_final_frame
//  output   | o_out_valid / i_out_ready | o_out_sample, o_run_end
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
//  One shared multiply/interpolate/gain path runs per output word of a frame.
//  A register write holds off frames during its access and the gain division that follows.
//  Reset is synchronous; no clearing pass is needed.
//  A stalled output word holds the sequencer in the emit step of the next word.
`timescale 1ns / 1ps
`default_nettype none
module linear_resampler_downmix_gain_unit #(
    parameter int MAX_UPSAMPLE = 8,
    parameter int MAX_VOICES   = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [lrdg_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [lrdg_pkg::DATA_W-1:0]           pwdata,
    output logic      [lrdg_pkg::DATA_W-1:0]           prdata,
    output logic                                       pready,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic signed [lrdg_pkg::SAMPLE_W-1:0]  i_left_sample,
    input  wire logic signed [lrdg_pkg::SAMPLE_W-1:0]  i_right_sample,
    input  wire logic                                  i_final_frame,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [lrdg_pkg::SAMPLE_W-1:0]       o_out_sample,
    output logic                                       o_run_end
);
    import lrdg_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign pready = 1'b1;

    lrdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lrdg_datapath #(
        .MAX_UPSAMPLE (MAX_UPSAMPLE),
        .MAX_VOICES   (MAX_VOICES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_final_frame  (i_final_frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_sample   (o_out_sample),
        .o_run_end      (o_run_end)
    );

endmodule
`default_nettype wire

// File: hw/rtl/lrdg_datapath.sv
// Datapath: register file, gain divider, phase state, interpolation and gain.
`timescale 1ns / 1ps
`default_nettype none
module lrdg_datapath #(
    parameter int MAX_UPSAMPLE = 8,
    parameter int MAX_VOICES   = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire lrdg_pkg::t_cmd                 i_cmd,
    output lrdg_pkg::t_status                   o_status,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lrdg_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lrdg_pkg::DATA_W-1:0]    pwdata,
    output logic      [lrdg_pkg::DATA_W-1:0]    prdata,
    input  wire logic signed [lrdg_pkg::SAMPLE_W-1:0] i_left_sample,
    input  wire logic signed [lrdg_pkg::SAMPLE_W-1:0] i_right_sample,
    input  wire logic                           i_final_frame,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [lrdg_pkg::SAMPLE_W-1:0] o_out_sample,
    output logic                                o_run_end
);
    import lrdg_pkg::*;

    localparam int KW       = $clog2(MAX_UPSAMPLE + 1);
    localparam int VW       = $clog2(MAX_VOICES + 1);
    localparam int STEP_MIN = (65536 + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;

    logic [POS_W-1:0]    r_phase_step;
    logic [15:0]         r_start_frac;
    logic                r_stereo;
    logic [GAIN_W-1:0]   r_voice_gain;
    logic [3:0]          r_active_voices;
    logic [GAIN_W-1:0]   r_eff_gain;

    logic [GAIN_W-1:0]   r_div_q;
    logic [VW-1:0]       r_div_rem;
    logic [3:0]          r_div_cnt;

    logic signed [SAMPLE_W-1:0] r_cur;
    logic                       r_fin;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic                       r_have_prev;
    logic [POS_W-1:0]           r_pos;
    logic [KW-1:0]              r_k;

    logic signed [33:0]         r_mul;
    logic signed [SAMPLE_W-1:0] r_interp;
    logic signed [31:0]         r_gmul;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_run_end;

    logic                       wr;
    logic [2:0]                 idx;
    logic [VW-1:0]              voices;
    logic [GAIN_W-1:0]          gain_lim;
    logic [VW:0]                trial;
    logic                       ge;
    logic [VW-1:0]              rem_next;
    logic [GAIN_W-1:0]          q_next;
    logic [POS_W-1:0]           step_used;
    logic [POS_W-1:0]           next_pos;
    logic                       more;
    logic                       b_follows;
    logic                       run_end_val;
    logic signed [SAMPLE_W:0]   lr_sum;
    logic signed [SAMPLE_W:0]   lr_half;
    logic signed [SAMPLE_W-1:0] mixed;
    logic signed [SAMPLE_W-1:0] s1;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [33:0]         num;
    logic signed [33:0]         num_q;
    logic signed [31:0]         g_q;
    logic signed [SAMPLE_W-1:0] g_sat;
    logic signed [SAMPLE_W-1:0] out_val;
    logic                       out_free;

    assign wr  = psel & penable & pwrite;
    assign idx = paddr[4:2];

    always_comb begin
        case (idx)
            REG_PHASE_STEP:    prdata = {{(DATA_W-POS_W){1'b0}}, r_phase_step};
            REG_START_FRAC:    prdata = {16'b0, r_start_frac};
            REG_STEREO_MODE:   prdata = {31'b0, r_stereo};
            REG_VOICE_GAIN:    prdata = {{(DATA_W-GAIN_W){1'b0}}, r_voice_gain};
            REG_ACTIVE_VOICES: prdata = {28'b0, r_active_voices};
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        if (r_active_voices == 4'd0) begin
            voices = VW'(1);
        end else if (32'(r_active_voices) > MAX_VOICES) begin
            voices = VW'(MAX_VOICES);
        end else begin
            voices = VW'(r_active_voices);
        end
        gain_lim = (r_voice_gain > GAIN_LIMIT) ? GAIN_LIMIT : r_voice_gain;
    end

    assign trial    = {r_div_rem, r_div_q[GAIN_W-1]};
    assign ge       = trial >= {1'b0, voices};
    assign rem_next = ge ? VW'(trial - {1'b0, voices}) : trial[VW-1:0];
    assign q_next   = {r_div_q[GAIN_W-2:0], ge};

    always_comb begin
        if (r_phase_step < POS_W'(STEP_MIN)) begin
            step_used = POS_W'(STEP_MIN);
        end else if (r_phase_step > STEP_LIMIT) begin
            step_used = STEP_LIMIT;
        end else begin
            step_used = r_phase_step;
        end
    end

    assign next_pos    = r_pos + step_used;
    assign more        = (next_pos < ONE_POS) && (r_k != KW'(MAX_UPSAMPLE - 1));
    assign b_follows   = r_fin && (next_pos >= ONE_POS) && (next_pos < TWO_POS);
    assign run_end_val = i_cmd.sel_b ? !more : (!more && !b_follows);

    assign lr_sum  = {i_left_sample[SAMPLE_W-1], i_left_sample}
                   + {i_right_sample[SAMPLE_W-1], i_right_sample};
    assign lr_half = (lr_sum + {{SAMPLE_W{1'b0}}, lr_sum[SAMPLE_W]}) >>> 1;
    assign mixed   = r_stereo ? lr_half[SAMPLE_W-1:0] : i_left_sample;

    assign s1   = i_cmd.sel_b ? r_cur : r_prev;
    assign diff = {r_cur[SAMPLE_W-1], r_cur} - {s1[SAMPLE_W-1], s1};

    always_comb begin
        num   = {{2{s1[SAMPLE_W-1]}}, s1, 16'b0} + r_mul;
        num_q = num >>> 16;
        if (num[33] && (num[15:0] != 16'b0)) begin
            num_q = num_q + 34'sd1;
        end
    end

    always_comb begin
        g_q = r_gmul >>> 12;
        if (r_gmul[31] && (r_gmul[11:0] != 12'b0)) begin
            g_q = g_q + 32'sd1;
        end
        if (g_q > 32'sd32767) begin
            g_sat = 16'sh7FFF;
        end else if (g_q < -32'sd32768) begin
            g_sat = -16'sh8000;
        end else begin
            g_sat = g_q[SAMPLE_W-1:0];
        end
        out_val = (r_eff_gain == UNITY_GAIN) ? r_interp : g_sat;
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step    <= 21'd65536;
            r_start_frac    <= '0;
            r_stereo        <= 1'b0;
            r_voice_gain    <= UNITY_GAIN;
            r_active_voices <= 4'd1;
            r_eff_gain      <= UNITY_GAIN;
            r_div_cnt       <= '0;
            r_prev          <= '0;
            r_have_prev     <= 1'b0;
            r_pos           <= '0;
            r_k             <= '0;
            r_fin           <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (wr) begin
                case (idx)
                    REG_PHASE_STEP:    r_phase_step    <= pwdata[POS_W-1:0];
                    REG_START_FRAC:    r_start_frac    <= pwdata[15:0];
                    REG_STEREO_MODE:   r_stereo        <= pwdata[0];
                    REG_VOICE_GAIN:    r_voice_gain    <= pwdata[GAIN_W-1:0];
                    REG_ACTIVE_VOICES: r_active_voices <= pwdata[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.div_load) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 4'd1;
                if (r_div_cnt == 4'(GAIN_W - 1)) begin
                    r_eff_gain <= q_next;
                end
            end
            if (i_cmd.accept) begin
                r_fin <= i_final_frame;
                r_k   <= '0;
            end
            if (i_cmd.load_start) begin
                r_pos <= {{(POS_W-16){1'b0}}, r_start_frac};
                r_k   <= '0;
            end
            if (i_cmd.wrap) begin
                r_pos <= r_pos - ONE_POS;
                r_k   <= '0;
            end
            if (i_cmd.emit) begin
                r_pos <= next_pos;
                r_k   <= r_k + KW'(1);
            end
            if (i_cmd.commit) begin
                if (r_fin) begin
                    r_have_prev <= 1'b0;
                    r_prev      <= '0;
                    r_pos       <= '0;
                end else begin
                    r_have_prev <= 1'b1;
                    r_prev      <= r_cur;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div_q   <= gain_lim;
            r_div_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_div_q   <= q_next;
            r_div_rem <= rem_next;
        end
        if (i_cmd.accept) begin
            r_cur <= mixed;
        end
        if (i_cmd.mul) begin
            r_mul <= diff * $signed({1'b0, r_pos[15:0]});
        end
        if (i_cmd.mix) begin
            r_interp <= num_q[SAMPLE_W-1:0];
        end
        if (i_cmd.gmul) begin
            r_gmul <= r_interp * $signed({1'b0, r_eff_gain});
        end
        if (i_cmd.emit) begin
            r_out_sample <= out_val;
            r_run_end    <= run_end_val;
        end
    end

    assign o_status.have_prev = r_have_prev;
    assign o_status.fin       = r_fin;
    assign o_status.in_range  = (r_pos < ONE_POS) && (r_k < KW'(MAX_UPSAMPLE));
    assign o_status.out_free  = out_free;
    assign o_status.cfg_wr    = wr;
    assign o_status.div_last  = r_div_cnt == 4'(GAIN_W - 1);

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_run_end    = r_run_end;

endmodule
`default_nettype wire

// File: hw/rtl/lrdg_ctrl.sv
// Controller: sequences frame intake, interpolation intervals and gain division.
`timescale 1ns / 1ps
`default_nettype none
module lrdg_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire lrdg_pkg::t_status  i_status,
    output lrdg_pkg::t_cmd          o_cmd
);
    import lrdg_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_TEST  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_MIX   = 4'd4;
    localparam logic [3:0] S_GMUL  = 4'd5;
    localparam logic [3:0] S_EMIT  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_DLOAD = 4'd8;
    localparam logic [3:0] S_DRUN  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_in_b;
    logic       n_in_b;
    logic       ready;

    assign ready      = (r_state == S_IDLE) && !i_status.cfg_wr;
    assign o_in_ready = ready;

    always_comb begin
        n_state = r_state;
        n_in_b  = r_in_b;
        o_cmd   = '0;
        o_cmd.sel_b = r_in_b;
        case (r_state)
            S_IDLE: begin
                if (i_status.cfg_wr) begin
                    n_state = S_DLOAD;
                end else if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_START;
                end
            end
            S_START: begin
                if (i_status.have_prev) begin
                    n_in_b  = 1'b0;
                    n_state = S_TEST;
                end else begin
                    o_cmd.load_start = 1'b1;
                    if (i_status.fin) begin
                        n_in_b  = 1'b1;
                        n_state = S_TEST;
                    end else begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_TEST: begin
                if (i_status.in_range) begin
                    n_state = S_MUL;
                end else if (!r_in_b) begin
                    o_cmd.wrap = 1'b1;
                    n_state    = S_FIN;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_GMUL;
            end
            S_GMUL: begin
                o_cmd.gmul = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_FIN: begin
                if (i_status.fin) begin
                    n_in_b  = 1'b1;
                    n_state = S_TEST;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                if (!i_status.cfg_wr) begin
                    n_state = S_DRUN;
                end
            end
            S_DRUN: begin
                if (i_status.cfg_wr) begin
                    n_state = S_DLOAD;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_in_b  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_in_b  <= n_in_b;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/lrdg_checker.sv
// Port-level checker for the resampler top level, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module lrdg_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  psel,
    input wire logic                                  penable,
    input wire logic                                  pwrite,
    input wire logic                                  i_in_valid,
    input wire logic                                  o_in_ready,
    input wire logic                                  o_out_valid,
    input wire logic                                  i_out_ready,
    input wire logic signed [lrdg_pkg::SAMPLE_W-1:0]  o_out_sample,
    input wire logic                                  o_run_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_sample) && $stable(o_run_end)))
        else $error("output word changed while stalled");

    a_no_take_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |-> !o_in_ready)
        else $error("input ready during register write");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready && !$rose(o_out_valid)))
        else $error("frame intake not followed by busy cycle");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind linear_resampler_downmix_gain_unit lrdg_checker u_lrdg_checker (.*);
`default_nettype wire
